// ===== rtl/sbr_pkg.sv =====
// Shared types and constants of the spotlight beam rasterizer.
// No dependencies; imported by sbr_beam and spotlight_beam_rasterizer.
package sbr_pkg;

    localparam int COORD_W     = 6;
    localparam int LEVEL_W     = 5;
    localparam int HALF_W      = 5;
    localparam int SPOT_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;
    localparam int NUM_BEAMS   = 3;

    localparam logic [COORD_W-1:0] SRC_ROW        = 6'd3;
    localparam logic [COORD_W-1:0] MIN_TARGET_ROW = 6'd4;
    localparam logic [COORD_W-1:0] SRC_X_EVEN     = 6'd8;
    localparam logic [COORD_W-1:0] SRC_X_ODD      = 6'd55;

    localparam logic [LEVEL_W-1:0] BASE_LEVEL = 5'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 5'd31;
    localparam logic [LEVEL_W-1:0] CONE_FLOOR = 5'd4;
    localparam logic [LEVEL_W-1:0] POOL_BONUS = 5'd11;

    localparam logic [3:0] FALLOFF_GAIN = 4'd14;
    localparam logic [4:0] POOL_ASPECT  = 5'd25;
    localparam logic [8:0] ALONG_LIMIT  = 9'd300;
    localparam logic [8:0] CONE_ONE     = 9'd256;

    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int ALONG_SHIFT = RECIP_SHIFT - 8;
    localparam int ALONG_W     = 15;
    localparam int DIV_BITS    = 9;
    localparam int DIV_NUMER   = 65536;

    localparam int BEAM_LATENCY  = DIV_BITS + 5;
    localparam int TOTAL_LATENCY = BEAM_LATENCY + 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SPOT_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BEAM_X_A   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BEAM_X_B   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BEAM_X_C   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POOL_Y_A   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POOL_Y_B   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_POOL_Y_C   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] aim_col;
        logic [COORD_W-1:0] aim_row;
        logic [HALF_W-1:0]  half_width;
    } beam_cfg_t;

endpackage

// ===== rtl/sbr_beam.sv =====
// Pipelined light level of one beam at one pixel: cone position, reciprocal
// divider, falloff and floor pool. Depends on sbr_pkg.
module sbr_beam (
    input  logic                          clk,
    input  logic [sbr_pkg::COORD_W-1:0]   src_x,
    input  sbr_pkg::beam_cfg_t            cfg,
    input  logic [sbr_pkg::COORD_W-1:0]   px,
    input  logic [sbr_pkg::COORD_W-1:0]   py,
    output logic [sbr_pkg::LEVEL_W-1:0]   level
);
    import sbr_pkg::*;

    logic [COORD_W-1:0] target_row;
    logic [COORD_W-1:0] along_div;
    logic [RECIP_W-1:0] recip_tbl [64];
    logic signed [6:0]  dx;
    logic signed [6:0]  dy;
    logic signed [13:0] dx_sq;
    logic signed [13:0] dy_sq;

    logic [RECIP_W-1:0] recip_b1_reg;
    logic [COORD_W-1:0] rows_b1_reg;
    logic               ge3_b1_reg;
    logic [COORD_W-1:0] px_b1_reg;
    logic [12:0]        dxsq_b1_reg;
    logic [11:0]        dysq_b1_reg;
    logic [9:0]         hsq_b1_reg;

    logic [26:0]        along_prod;
    logic [ALONG_W-1:0] along_b2_reg;
    logic               ge3_b2_reg;
    logic [COORD_W-1:0] px_b2_reg;
    logic [16:0]        pa_b2_reg;
    logic [21:0]        pb_b2_reg;
    logic [14:0]        pc_b2_reg;

    logic [8:0]         along9;
    logic signed [6:0]  slope;
    logic signed [16:0] cone_off;
    logic signed [17:0] cx_b3_reg;
    logic [13:0]        hw_b3_reg;
    logic               ok_b3_reg;
    logic               pool_b3_reg;
    logic [COORD_W-1:0] px_b3_reg;

    logic signed [18:0] offset;
    logic signed [18:0] offset_abs;
    logic [14:0]        offset_mag;

    logic [16:0]        div_rem_reg  [DIV_BITS];
    logic [8:0]         div_quo_reg  [DIV_BITS];
    logic [13:0]        div_hw_reg   [DIV_BITS];
    logic [14:0]        div_d_reg    [DIV_BITS];
    logic               div_ok_reg   [DIV_BITS];
    logic               div_pool_reg [DIV_BITS];

    logic [23:0]        cross_prod;
    logic               near_b13_reg;
    logic [7:0]         cross_b13_reg;
    logic               ok_b13_reg;
    logic               pool_b13_reg;

    logic [12:0]        fall_prod;
    logic [LEVEL_W-1:0] level_next;
    logic [LEVEL_W-1:0] level_reg;

    for (genvar gi = 0; gi < 64; gi++) begin : g_recip
        localparam int unsigned RECIP =
            ((1 << RECIP_SHIFT) + gi - 1) / ((gi == 0) ? 1 : gi);
        assign recip_tbl[gi] = RECIP_W'(RECIP);
    end

    assign target_row = (cfg.aim_row < MIN_TARGET_ROW) ? MIN_TARGET_ROW : cfg.aim_row;
    assign along_div  = target_row - SRC_ROW;
    assign dx         = $signed({1'b0, px}) - $signed({1'b0, cfg.aim_col});
    assign dy         = $signed({1'b0, py}) - $signed({1'b0, target_row});
    assign dx_sq      = 14'(dx) * 14'(dx);
    assign dy_sq      = 14'(dy) * 14'(dy);

    always_ff @(posedge clk)
    begin
        recip_b1_reg <= recip_tbl[along_div];
        rows_b1_reg  <= py - SRC_ROW;
        ge3_b1_reg   <= (py >= SRC_ROW);
        px_b1_reg    <= px;
        dxsq_b1_reg  <= 13'(dx_sq);
        dysq_b1_reg  <= 12'(dy_sq);
        hsq_b1_reg   <= 10'(cfg.half_width) * 10'(cfg.half_width);
    end

    assign along_prod = 27'(rows_b1_reg) * 27'(recip_b1_reg);

    always_ff @(posedge clk)
    begin
        along_b2_reg <= along_prod[ALONG_SHIFT +: ALONG_W];
        ge3_b2_reg   <= ge3_b1_reg;
        px_b2_reg    <= px_b1_reg;
        pa_b2_reg    <= 17'(dxsq_b1_reg) * 17'(POOL_ASPECT);
        pb_b2_reg    <= 22'(dysq_b1_reg) * 22'(hsq_b1_reg);
        pc_b2_reg    <= 15'(hsq_b1_reg) * 15'(POOL_ASPECT);
    end

    assign along9   = along_b2_reg[8:0];
    assign slope    = $signed({1'b0, cfg.aim_col}) - $signed({1'b0, src_x});
    assign cone_off = 17'(slope) * 17'($signed({1'b0, along9}));

    always_ff @(posedge clk)
    begin
        cx_b3_reg   <= $signed({4'b0, src_x, 8'b0}) + 18'(cone_off);
        hw_b3_reg   <= 14'(CONE_ONE) + 14'(cfg.half_width) * 14'(along9);
        ok_b3_reg   <= ge3_b2_reg && (along_b2_reg <= ALONG_W'(ALONG_LIMIT));
        pool_b3_reg <= (23'(pa_b2_reg) + 23'(pb_b2_reg)) < 23'(pc_b2_reg);
        px_b3_reg   <= px_b2_reg;
    end

    assign offset     = $signed({5'b0, px_b3_reg, 8'b0}) - 19'(cx_b3_reg);
    assign offset_abs = (offset < 0) ? -offset : offset;
    assign offset_mag = offset_abs[14:0];

    // Restoring division of 65536 by the cone width, one quotient bit per stage.
    for (genvar gj = 0; gj < DIV_BITS; gj++) begin : g_div
        localparam int BIT = DIV_BITS - 1 - gj;
        logic [16:0] rem_in;
        logic [8:0]  quo_in;
        logic [13:0] hw_in;
        logic [14:0] d_in;
        logic        ok_in;
        logic        pool_in;
        logic [22:0] trial;
        logic        take;

        if (gj == 0) begin : g_first
            assign rem_in  = 17'(DIV_NUMER);
            assign quo_in  = '0;
            assign hw_in   = hw_b3_reg;
            assign d_in    = offset_mag;
            assign ok_in   = ok_b3_reg;
            assign pool_in = pool_b3_reg;
        end else begin : g_next
            assign rem_in  = div_rem_reg[gj-1];
            assign quo_in  = div_quo_reg[gj-1];
            assign hw_in   = div_hw_reg[gj-1];
            assign d_in    = div_d_reg[gj-1];
            assign ok_in   = div_ok_reg[gj-1];
            assign pool_in = div_pool_reg[gj-1];
        end

        assign trial = 23'(hw_in) << BIT;
        assign take  = 23'(rem_in) >= trial;

        always_ff @(posedge clk)
        begin
            div_rem_reg[gj]  <= take ? 17'(23'(rem_in) - trial) : rem_in;
            div_quo_reg[gj]  <= quo_in | (9'(take) << BIT);
            div_hw_reg[gj]   <= hw_in;
            div_d_reg[gj]    <= d_in;
            div_ok_reg[gj]   <= ok_in;
            div_pool_reg[gj] <= pool_in;
        end
    end

    assign cross_prod = 24'(div_d_reg[DIV_BITS-1]) * 24'(div_quo_reg[DIV_BITS-1]);

    always_ff @(posedge clk)
    begin
        near_b13_reg  <= (cross_prod[23:16] == 8'd0);
        cross_b13_reg <= cross_prod[15:8];
        ok_b13_reg    <= div_ok_reg[DIV_BITS-1];
        pool_b13_reg  <= div_pool_reg[DIV_BITS-1];
    end

    assign fall_prod = 13'(CONE_ONE - 9'(cross_b13_reg)) * 13'(FALLOFF_GAIN);

    always_comb
    begin
        level_next = '0;
        if (ok_b13_reg && near_b13_reg)
        begin
            level_next = CONE_FLOOR + fall_prod[12:8]
                       + (pool_b13_reg ? POOL_BONUS : 5'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

// ===== rtl/spotlight_beam_rasterizer.sv =====
// Top level of the spotlight beam rasterizer: configuration registers,
// three beam pipelines, marker test and saturating sum. Depends on sbr_pkg, sbr_beam.
//
// Usage:
//   A pixel transfer happens at a rising edge where start is high and busy is
//   low. busy never rises, so a new pixel may be given on every cycle.
//   Each pixel yields one brightness value, shown on brightness while done is
//   high for one cycle; results keep the order of the pixels. Throughput is
//   one pixel per cycle; each pixel passes the input register, the nine stages
//   of the per-beam reciprocal divider, five stages of cone and pool math and
//   the output register. The receiver cannot stall: a result is valid for
//   exactly its one cycle. Configuration writes use cfg_write, cfg_index and
//   cfg_data and take effect at the same edge; the user makes them only while
//   no pixel is in flight, and the block does not enforce this.
//   Reset clears the pipeline valid bits and returns the registers to their
//   defaults: no active beams, targets at column 31 and row 54, half width 13.
module spotlight_beam_rasterizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sbr_pkg::COORD_W-1:0]       pixel_x,
    input  logic [sbr_pkg::COORD_W-1:0]       pixel_y,
    input  logic                              cfg_write,
    input  logic [sbr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sbr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output logic [sbr_pkg::LEVEL_W-1:0]       brightness
);
    import sbr_pkg::*;

    localparam logic [COORD_W-1:0] MARKER_ROW_FIRST = 6'd1;
    localparam logic [COORD_W-1:0] MARKER_ROW_LAST  = 6'd4;
    localparam logic [6:0]         MARKER_REACH     = 7'd2;

    logic [SPOT_W-1:0]  spot_count_reg;
    logic [COORD_W-1:0] beam_x_reg [NUM_BEAMS];
    logic [COORD_W-1:0] pool_y_reg [NUM_BEAMS];
    logic [HALF_W-1:0]  half_width_reg;

    logic               accept;
    logic               marker_row;
    logic               near_even;
    logic               near_odd;
    logic               marker;

    logic               valid_in_reg;
    logic               marker_in_reg;
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;

    logic [BEAM_LATENCY-1:0] valid_pipe_reg;
    logic [BEAM_LATENCY-1:0] marker_pipe_reg;

    beam_cfg_t          beam_cfg   [NUM_BEAMS];
    logic [LEVEL_W-1:0] beam_level [NUM_BEAMS];
    logic [LEVEL_W-1:0] beam_gated [NUM_BEAMS];

    logic [6:0]         level_sum;
    logic [LEVEL_W-1:0] brightness_next;
    logic               done_reg;
    logic [LEVEL_W-1:0] brightness_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spot_count_reg <= '0;
            for (int k = 0; k < NUM_BEAMS; k++)
            begin
                beam_x_reg[k] <= 6'd31;
                pool_y_reg[k] <= 6'd54;
            end
            half_width_reg <= 5'd13;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SPOT_COUNT: spot_count_reg  <= cfg_data[SPOT_W-1:0];
                REG_BEAM_X_A:   beam_x_reg[0]   <= cfg_data;
                REG_BEAM_X_B:   beam_x_reg[1]   <= cfg_data;
                REG_BEAM_X_C:   beam_x_reg[2]   <= cfg_data;
                REG_POOL_Y_A:   pool_y_reg[0]   <= cfg_data;
                REG_POOL_Y_B:   pool_y_reg[1]   <= cfg_data;
                REG_POOL_Y_C:   pool_y_reg[2]   <= cfg_data;
                REG_HALF_WIDTH: half_width_reg  <= cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Source markers: beams zero and two share the left source.
    assign marker_row = (pixel_y >= MARKER_ROW_FIRST) && (pixel_y <= MARKER_ROW_LAST);
    assign near_even  = (7'(pixel_x) + MARKER_REACH >= 7'(SRC_X_EVEN))
                     && (7'(pixel_x) <= 7'(SRC_X_EVEN) + MARKER_REACH);
    assign near_odd   = (7'(pixel_x) + MARKER_REACH >= 7'(SRC_X_ODD))
                     && (7'(pixel_x) <= 7'(SRC_X_ODD) + MARKER_REACH);
    assign marker     = marker_row
                     && (((spot_count_reg != 2'd0) && near_even)
                      || ((spot_count_reg >= 2'd2) && near_odd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_in_reg    <= 1'b0;
            valid_pipe_reg  <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            valid_in_reg    <= accept;
            valid_pipe_reg  <= {valid_pipe_reg[BEAM_LATENCY-2:0], valid_in_reg};
            done_reg        <= valid_pipe_reg[BEAM_LATENCY-1];
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg          <= pixel_x;
        py_reg          <= pixel_y;
        marker_in_reg   <= marker;
        marker_pipe_reg <= {marker_pipe_reg[BEAM_LATENCY-2:0], marker_in_reg};
        brightness_reg  <= brightness_next;
    end

    for (genvar gk = 0; gk < NUM_BEAMS; gk++) begin : g_beam
        assign beam_cfg[gk].aim_col    = beam_x_reg[gk];
        assign beam_cfg[gk].aim_row    = pool_y_reg[gk];
        assign beam_cfg[gk].half_width = half_width_reg;

        sbr_beam u_beam (
            .clk   (clk),
            .src_x ((gk % 2 == 1) ? SRC_X_ODD : SRC_X_EVEN),
            .cfg   (beam_cfg[gk]),
            .px    (px_reg),
            .py    (py_reg),
            .level (beam_level[gk])
        );

        assign beam_gated[gk] = (spot_count_reg > SPOT_W'(gk)) ? beam_level[gk] : '0;
    end

    assign level_sum = 7'(BASE_LEVEL) + 7'(beam_gated[0]) + 7'(beam_gated[1])
                     + 7'(beam_gated[2]);

    assign brightness_next = ((level_sum > 7'(LEVEL_MAX)) || marker_pipe_reg[BEAM_LATENCY-1])
                           ? LEVEL_MAX : level_sum[LEVEL_W-1:0];

    assign done       = done_reg;
    assign brightness = brightness_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LATENCY done)
        else $error("Accepted pixel produced no result at the expected cycle.");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, TOTAL_LATENCY))
        else $error("Result strobe without a matching pixel transfer.");

    a_marker_full: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_pipe_reg[BEAM_LATENCY-1] && marker_pipe_reg[BEAM_LATENCY-1])
            |=> (done && brightness == LEVEL_MAX))
        else $error("Source marker pixel did not read full brightness.");

endmodule
